// ----- hdl/bgp_pkg.sv -----
// Types, codes and tap table function for the bicubic grid prolongation block.
package bgp_pkg;

  localparam int SAMPLE_W = 32;
  localparam int IDX_W    = 7;   // coarse index along one axis, bounded by the 7-bit registers
  localparam int WGT_W    = 6;   // signed tap weight over 16
  localparam int PART_W   = 38;  // one x pass: at most 20 * 2^31 in magnitude
  localparam int NUM_W    = 44;  // both passes: at most 400 * 2^31 in magnitude

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic REG_COARSE_COLS = 1'b0;
  localparam logic REG_COARSE_ROWS = 1'b1;

  // Weights over 16, two's complement in WGT_W bits
  localparam logic [WGT_W-1:0] W_COPY  = 6'd16;
  localparam logic [WGT_W-1:0] W_HALF  = 6'd8;
  localparam logic [WGT_W-1:0] W_ONE_A = 6'd6;
  localparam logic [WGT_W-1:0] W_ONE_B = 6'd12;
  localparam logic [WGT_W-1:0] W_ONE_C = 6'h3E;  // -2
  localparam logic [WGT_W-1:0] W_IN    = 6'd9;
  localparam logic [WGT_W-1:0] W_OUT   = 6'h3F;  // -1

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]                  cnt;
    logic [3:0][IDX_W-1:0]       idx;
    logic [3:0][WGT_W-1:0]       w;
  } taps_t;

  // Coarse taps for fine index f (f <= 2*n) on an axis of n intervals
  function automatic taps_t make_taps(input logic [7:0] f, input logic [IDX_W-1:0] n,
                                      input logic cubic);
    taps_t            t;
    logic [IDX_W-1:0] k;
    t = '0;
    k = f[7:1];
    if (!f[0]) begin
      t.cnt    = 3'd1;
      t.idx[0] = k;
      t.w[0]   = W_COPY;
    end else if (!cubic) begin
      t.cnt    = 3'd2;
      t.idx[0] = k;
      t.idx[1] = k + 7'd1;
      t.w[0]   = W_HALF;
      t.w[1]   = W_HALF;
    end else if (k == 7'd0) begin
      t.cnt    = 3'd3;
      t.idx[0] = 7'd0;
      t.idx[1] = 7'd1;
      t.idx[2] = 7'd2;
      t.w[0]   = W_ONE_A;
      t.w[1]   = W_ONE_B;
      t.w[2]   = W_ONE_C;
    end else if (k == n - 7'd1) begin
      t.cnt    = 3'd3;
      t.idx[0] = n - 7'd2;
      t.idx[1] = n - 7'd1;
      t.idx[2] = n;
      t.w[0]   = W_ONE_C;
      t.w[1]   = W_ONE_B;
      t.w[2]   = W_ONE_A;
    end else begin
      t.cnt    = 3'd4;
      t.idx[0] = k - 7'd1;
      t.idx[1] = k;
      t.idx[2] = k + 7'd1;
      t.idx[3] = k + 7'd2;
      t.w[0]   = W_OUT;
      t.w[1]   = W_IN;
      t.w[2]   = W_IN;
      t.w[3]   = W_OUT;
    end
    return t;
  endfunction

endpackage

// ----- hdl/bicubic_grid_prolongation_top.sv -----
// Top level of the bicubic grid prolongation block: coarse sample store and tap sequencer.

// A load transfer writes one coarse sample into a single-port store of
// (MAX_INTERVALS+1)^2 words and gives no result; a load with col or row
// above MAX_INTERVALS is dropped. A read transfer names a fine point; the
// block fetches its 1, 2, 3, 4, 9, 12 or 16 coarse taps one per cycle from
// the store, so the input stalls until the read's result has gone to the
// output register, and an index outside the grid returns range_error with no
// fetch. The store port is what sets that rate. The output register lets the
// next transfer be taken while a result still waits. The store has no reset
// and no clearing pass: every entry a read touches must have been loaded first.
module bicubic_grid_prolongation_top
  import bgp_pkg::*;
#(
  parameter int MAX_INTERVALS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [6:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [7:0]                 in_col,
  input  logic [7:0]                 in_row,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_fine_value,
  output logic                       out_range_error
);

  localparam int GRID_SIDE  = MAX_INTERVALS + 1;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);

  localparam logic signed [NUM_W-1:0] SAT_MAX = 44'sh000_7FFF_FFFF;
  localparam logic signed [NUM_W-1:0] SAT_MIN = 44'shFFF_8000_0000;
  localparam logic signed [NUM_W-1:0] RND_HALF = 44'sd128;

  state_t state_r, state_nxt;

  logic [6:0] cols_r, rows_r;
  logic [IDX_W-1:0] nx, ny;
  logic cubic;

  logic in_accept, rd_accept, ld_accept, rd_oob, ld_in_store;
  logic out_free;

  taps_t tx_r, ty_r;
  logic [1:0] a_r, b_r;
  logic tap_eor, tap_last;

  logic [SAMPLE_W-1:0] mem [GRID_DEPTH];
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic signed [SAMPLE_W-1:0] rd_data_r;

  logic             p1_valid_r, p1_eor_r, p1_last_r;
  logic [WGT_W-1:0] p1_wx_r, p1_wy_r;
  logic             p2_valid_r, p2_eor_r, p2_last_r;
  logic [WGT_W-1:0] p2_wy_r;
  logic signed [PART_W-1:0] prod_r, part_r, rowv_r, part_sum;
  logic             p3_valid_r, p3_last_r;
  logic [WGT_W-1:0] p3_wy_r;
  logic signed [NUM_W-1:0] rowprod_r, num_r, num_tot, num_rnd;
  logic             p4_valid_r, p4_last_r;

  logic signed [SAMPLE_W-1:0] res_value_r, sat_value;
  logic                       res_err_r;
  logic                       out_valid_r, out_err_r;
  logic signed [SAMPLE_W-1:0] out_value_r;

  // Interval counts as used: zero reads as one, beyond the store reads as its size
  always_comb begin
    nx = (cols_r == 7'd0) ? 7'd1 : cols_r;
    ny = (rows_r == 7'd0) ? 7'd1 : rows_r;
    if (32'(nx) > 32'(MAX_INTERVALS)) nx = 7'(MAX_INTERVALS);
    if (32'(ny) > 32'(MAX_INTERVALS)) ny = 7'(MAX_INTERVALS);
    cubic = (nx >= 7'd2) && (ny >= 7'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 7'd1;
      rows_r <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COARSE_COLS: cols_r <= cfg_data;
        REG_COARSE_ROWS: rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_accept   = in_valid && !in_stall;
  assign rd_accept   = in_accept && (in_command == CMD_READ);
  assign ld_accept   = in_accept && (in_command == CMD_LOAD);
  assign rd_oob      = (in_col > {nx, 1'b0}) || (in_row > {ny, 1'b0});
  assign ld_in_store = (32'(in_col) <= 32'(MAX_INTERVALS)) &&
                       (32'(in_row) <= 32'(MAX_INTERVALS));
  assign out_free    = !out_valid_r || !out_stall;

  assign tap_eor  = ({1'b0, a_r} == tx_r.cnt - 3'd1);
  assign tap_last = tap_eor && ({1'b0, b_r} == ty_r.cnt - 3'd1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (rd_accept) state_nxt = rd_oob ? S_EMIT : S_FETCH;
      S_FETCH: if (tap_last) state_nxt = S_DRAIN;
      S_DRAIN: if (p4_valid_r && p4_last_r) state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    mem_addr = ADDR_W'(ty_r.idx[b_r]) * ADDR_W'(GRID_SIDE) + ADDR_W'(tx_r.idx[a_r]);
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        mem_we   = ld_accept && ld_in_store;
        mem_addr = ADDR_W'(in_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(in_col);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Tap lists are captured at the read transfer and walked row by row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 2'd0;
      b_r <= 2'd0;
    end else if (state_r == S_FETCH) begin
      if (tap_eor) begin
        a_r <= 2'd0;
        b_r <= tap_last ? 2'd0 : b_r + 2'd1;
      end else begin
        a_r <= a_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_accept) begin
      tx_r <= make_taps(in_col, nx, cubic);
      ty_r <= make_taps(in_row, ny, cubic);
    end
  end

  // Single-port store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= in_sample_value;
    rd_data_r <= mem[mem_addr];
  end

  assign part_sum = part_r + prod_r;
  assign num_tot  = num_r + rowprod_r;
  assign num_rnd  = (num_tot + RND_HALF) >>> 8;

  always_comb begin
    if (num_rnd > SAT_MAX) sat_value = SAT_MAX[SAMPLE_W-1:0];
    else if (num_rnd < SAT_MIN) sat_value = SAT_MIN[SAMPLE_W-1:0];
    else sat_value = num_rnd[SAMPLE_W-1:0];
  end

  // Accumulation pipeline: x weight multiply, row sum, y weight multiply, total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      part_r     <= '0;
      num_r      <= '0;
    end else begin
      p1_valid_r <= (state_r == S_FETCH);
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r && p2_eor_r;
      p4_valid_r <= p3_valid_r;
      if (p2_valid_r) part_r <= p2_eor_r ? '0 : part_sum;
      if (p4_valid_r) num_r <= p4_last_r ? '0 : num_tot;
    end
  end

  always_ff @(posedge clk) begin
    p1_wx_r   <= tx_r.w[a_r];
    p1_wy_r   <= ty_r.w[b_r];
    p1_eor_r  <= tap_eor;
    p1_last_r <= tap_last;
    prod_r    <= PART_W'($signed(p1_wx_r)) * PART_W'(rd_data_r);
    p2_wy_r   <= p1_wy_r;
    p2_eor_r  <= p1_eor_r;
    p2_last_r <= p1_last_r;
    if (p2_valid_r && p2_eor_r) rowv_r <= part_sum;
    p3_wy_r   <= p2_wy_r;
    p3_last_r <= p2_last_r;
    rowprod_r <= NUM_W'($signed(p3_wy_r)) * NUM_W'(rowv_r);
    p4_last_r <= p3_last_r;
  end

  always_ff @(posedge clk) begin
    if (rd_accept && rd_oob) begin
      res_value_r <= '0;
      res_err_r   <= 1'b1;
    end else if (p4_valid_r && p4_last_r) begin
      res_value_r <= sat_value;
      res_err_r   <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_value_r <= res_value_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fine_value  = out_value_r;
  assign out_range_error = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_value_r == '0))
    else $error("range error result carries a nonzero value");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(p1_valid_r || p2_valid_r || p3_valid_r || p4_valid_r))
    else $error("accumulation pipeline busy while idle");

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (p4_valid_r && p4_last_r) |-> (state_r == S_DRAIN))
    else $error("final tap total outside drain");

  a_tap_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (({1'b0, a_r} < tx_r.cnt) && ({1'b0, b_r} < ty_r.cnt)))
    else $error("tap counter beyond tap list");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && out_stall) |=> (state_r == S_EMIT))
    else $error("result left emit while output register full");

endmodule

// ----- bench/tb_bicubic_grid_prolongation_top.sv -----
// Self-checking testbench for the bicubic grid prolongation top level.
`timescale 1ns / 100ps

module tb_bicubic_grid_prolongation_top;
  import bgp_pkg::*;

  localparam int COARSE_MAX    = 64;
  localparam int GRID_SIDE     = COARSE_MAX + 1;
  localparam int GRID_CELLS    = GRID_SIDE * GRID_SIDE;
  localparam int SETTLE_CYCLES = 30;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 13;
  localparam int HOLD_PHASE    = 4;

  localparam logic [31:0] SAT_HI = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_LO = 32'h8000_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] fine_value;
    logic                       range_error;
  } fine_point_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_READ, ROW_CFG} script_kind_t;

  typedef struct packed {
    script_kind_t kind;
    logic         cfg_sel;
    logic [7:0]   col;
    logic [7:0]   row;
    logic [31:0]  val;
    logic         lit;
    logic [31:0]  lit_value;
    logic         lit_err;
  } script_row_t;

  localparam fine_point_t NO_LIT = '0;
  localparam int SCRIPT_ROWS = 29;

  // Linear grid at reset values first, then the smallest cubic grid with a
  // sign pattern that drives the one-sided corner point into saturation.
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_LOAD, REG_COARSE_COLS, 8'd0,   8'd0,   SAT_HI,        1'b0, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd0,   8'd0,   32'hDEAD_BEEF, 1'b1, SAT_HI, 1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd1,   8'd0,   SAT_LO,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd0,   8'd1,   32'd0,         1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd1,   8'd1,   32'h0001_0000, 1'b0, 32'd0,  1'b0},
    // dropped loads; the first would alias coarse (0,1) if the index wrapped
    '{ROW_LOAD, REG_COARSE_COLS, 8'd65,  8'd0,   32'h1234_5678, 1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd0,   8'd255, 32'hFFFF_FFFF, 1'b0, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd0,   8'd2,   32'd0,         1'b1, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd1,   8'd0,   32'd0,         1'b0, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd1,   8'd1,   32'd0,         1'b0, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd2,   8'd2,   32'hFFFF_FFFF, 1'b1, 32'h0001_0000, 1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd3,   8'd0,   32'd0,         1'b1, 32'd0,  1'b1},
    '{ROW_READ, REG_COARSE_COLS, 8'd0,   8'd3,   32'd0,         1'b1, 32'd0,  1'b1},
    '{ROW_READ, REG_COARSE_COLS, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'd0,  1'b1},
    '{ROW_CFG,  REG_COARSE_COLS, 8'd0,   8'd0,   32'd2,         1'b0, 32'd0,  1'b0},
    '{ROW_CFG,  REG_COARSE_ROWS, 8'd0,   8'd0,   32'd2,         1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd1,   8'd0,   SAT_HI,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd2,   8'd0,   SAT_LO,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd0,   8'd1,   SAT_HI,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd1,   8'd1,   SAT_HI,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd2,   8'd1,   SAT_LO,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd0,   8'd2,   SAT_LO,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd1,   8'd2,   SAT_LO,        1'b0, 32'd0,  1'b0},
    '{ROW_LOAD, REG_COARSE_COLS, 8'd2,   8'd2,   SAT_HI,        1'b0, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd1,   8'd1,   32'd0,         1'b1, SAT_HI, 1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd3,   8'd3,   32'd0,         1'b0, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd4,   8'd4,   32'd0,         1'b1, SAT_HI, 1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd2,   8'd1,   32'd0,         1'b0, 32'd0,  1'b0},
    '{ROW_READ, REG_COARSE_COLS, 8'd5,   8'd0,   32'd0,         1'b1, 32'd0,  1'b1}
  };

  // Register settings per random phase, extremes included (0, 65 and 127 clamp)
  localparam int PH_COLS   [PHASES] = '{0, 1, 2, 3, 4, 127, 5, 2, 3, 7, 127, 64, 8};
  localparam int PH_ROWS   [PHASES] = '{0, 5, 3, 2, 4, 1, 7, 65, 0, 6, 127, 2, 8};
  localparam int PH_BUDGET [PHASES] = '{100, 110, 120, 120, 130, 100, 120, 90, 90, 120,
                                        80, 80, 110};

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = REG_COARSE_COLS;
  logic [6:0]                 cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_command = CMD_LOAD;
  logic [7:0]                 in_col = '0;
  logic [7:0]                 in_row = '0;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_fine_value;
  logic                       out_range_error;

  // Shadow of the block's state
  int          coarse_model [GRID_CELLS];
  bit          loaded [GRID_CELLS];
  logic [6:0]  cols_model = 7'd1;
  logic [6:0]  rows_model = 7'd1;
  fine_point_t expected_points [$];

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit long_hold_req = 1'b0;
  int cycle_count = 0;
  int n_fail = 0;
  int n_checked = 0;
  int n_loads = 0;
  int n_reads = 0;
  int n_offgrid = 0;
  int n_dropped = 0;
  int items_sent = 0;

  bicubic_grid_prolongation_top #(.MAX_INTERVALS(COARSE_MAX)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_col          (in_col),
    .in_row          (in_row),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fine_value  (out_fine_value),
    .out_range_error (out_range_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_points.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int eff_intervals(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > COARSE_MAX) return COARSE_MAX;
    return int'(v);
  endfunction

  function automatic bit cubic_mode();
    return eff_intervals(cols_model) >= 2 && eff_intervals(rows_model) >= 2;
  endfunction

  // Weight over 16 of coarse index c for fine index f on an axis of n intervals
  function automatic int tap_weight(input int f, input int n, input bit cubic, input int c);
    int k;
    k = f / 2;
    if (f % 2 == 0) return (c == k) ? 16 : 0;
    if (!cubic) return (c == k || c == k + 1) ? 8 : 0;
    if (k == 0) begin
      if (c == 0) return 6;
      if (c == 1) return 12;
      if (c == 2) return -2;
      return 0;
    end
    if (k == n - 1) begin
      if (c == n - 2) return -2;
      if (c == n - 1) return 12;
      if (c == n) return 6;
      return 0;
    end
    if (c == k - 1 || c == k + 2) return -1;
    if (c == k || c == k + 1) return 9;
    return 0;
  endfunction

  function automatic fine_point_t interpolate_fine(input int col, input int row);
    fine_point_t p;
    int          nx, ny, r, c, wx, wy;
    bit          cubic;
    longint      num, part, q;
    nx = eff_intervals(cols_model);
    ny = eff_intervals(rows_model);
    cubic = cubic_mode();
    p = '0;
    if (col > 2 * nx || row > 2 * ny) begin
      p.range_error = 1'b1;
      return p;
    end
    num = 0;
    for (r = row / 2 - 1; r <= row / 2 + 2; r++) begin
      wy = tap_weight(row, ny, cubic, r);
      if (wy != 0) begin
        part = 0;
        for (c = col / 2 - 1; c <= col / 2 + 2; c++) begin
          wx = tap_weight(col, nx, cubic, c);
          if (wx != 0) part += longint'(wx) * longint'(coarse_model[r * GRID_SIDE + c]);
        end
        num += longint'(wy) * part;
      end
    end
    // round half up: floor((num + 128) / 256)
    q = (num + 128) >>> 8;
    if (q > longint'(SAT_HI)) q = longint'(SAT_HI);
    if (q < -longint'(SAT_LO)) q = -longint'(SAT_LO);
    p.fine_value = q[31:0];
    return p;
  endfunction

  function automatic logic [31:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return SAT_HI;
      1:       return SAT_LO;
      2, 3:    return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: return $urandom();
    endcase
  endfunction

  function automatic int draw_coarse(input int n);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 255);
      1:       return $urandom_range(0, COARSE_MAX);
      default: return $urandom_range(0, n);
    endcase
  endfunction

  // Fine index biased toward both borders of the grid, with some off-grid
  function automatic int draw_fine(input int n);
    int f;
    case ($urandom_range(0, 11))
      0:       return $urandom_range(0, 255);
      1:       return 2 * n + 1;
      2, 3:    return $urandom_range(0, 3);
      4, 5: begin
        f = 2 * n - int'($urandom_range(0, 3));
        return (f < 0) ? 0 : f;
      end
      default: return $urandom_range(0, 2 * n);
    endcase
  endfunction

  task automatic send_item(input logic cmd, input int col, input int row,
                           input logic [31:0] val, input bit lit_on, input fine_point_t lit);
    int          gap;
    int          addr;
    fine_point_t p;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (cmd == CMD_LOAD) begin
      if (col <= COARSE_MAX && row <= COARSE_MAX) begin
        addr = row * GRID_SIDE + col;
        coarse_model[addr] = val;
        loaded[addr] = 1'b1;
        n_loads++;
        items_sent++;
      end else begin
        n_dropped++;
      end
    end else begin
      p = lit_on ? lit : interpolate_fine(col, row);
      expected_points.push_back(p);
      n_reads++;
      items_sent++;
      if (p.range_error) n_offgrid++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_col          <= col[7:0];
    in_row          <= row[7:0];
    in_sample_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Loads the coarse taps of a fine point: only missing ones with random
  // samples, or all of them with extremes signed to push the sum outward.
  task automatic prime_taps(input int col, input int row, input bit extreme);
    int          nx, ny, r, c, wx, wy;
    bit          cubic, flip;
    logic [31:0] v;
    nx = eff_intervals(cols_model);
    ny = eff_intervals(rows_model);
    cubic = cubic_mode();
    flip = $urandom_range(0, 1);
    if (col > 2 * nx || row > 2 * ny) return;
    for (r = row / 2 - 1; r <= row / 2 + 2; r++) begin
      wy = tap_weight(row, ny, cubic, r);
      for (c = col / 2 - 1; c <= col / 2 + 2; c++) begin
        wx = tap_weight(col, nx, cubic, c);
        if (wx != 0 && wy != 0) begin
          if (extreme) begin
            v = ((wx * wy > 0) ^ flip) ? SAT_HI : SAT_LO;
            send_item(CMD_LOAD, c, r, v, 1'b0, NO_LIT);
          end else if (!loaded[r * GRID_SIDE + c]) begin
            send_item(CMD_LOAD, c, r, draw_sample(), 1'b0, NO_LIT);
          end
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_points.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [6:0] val);
    wait_drained();
    // a trailing load may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_COARSE_COLS) cols_model = val;
    else rows_model = val;
  endtask

  // Result side: random stalls, one long hold on request
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    fine_point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result transfer: fine_value %h range_error %b",
               out_fine_value, out_range_error);
        n_fail++;
      end else begin
        want = expected_points.pop_front();
        n_checked++;
        if (out_fine_value !== want.fine_value) begin
          $error("fine_value: expected %h, got %h", want.fine_value, out_fine_value);
          n_fail++;
        end
        if (out_range_error !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error, out_range_error);
          n_fail++;
        end
      end
    end
  end

  initial begin
    script_row_t sr;
    fine_point_t lit_pt;
    int          ph, start, col, row, pick, nx, ny;
    bit          paused, hold_asked;
    hold_asked = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      sr = SCRIPT[i];
      lit_pt.fine_value  = sr.lit_value;
      lit_pt.range_error = sr.lit_err;
      if (sr.kind == ROW_CFG) write_reg(sr.cfg_sel, sr.val[6:0]);
      else send_item((sr.kind == ROW_READ) ? CMD_READ : CMD_LOAD, sr.col, sr.row, sr.val,
                     sr.lit, lit_pt);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_COARSE_COLS, PH_COLS[ph]);
      write_reg(REG_COARSE_ROWS, PH_ROWS[ph]);
      nx = eff_intervals(cols_model);
      ny = eff_intervals(rows_model);
      tx_steady = (ph % 4 == 2);
      rx_steady = (ph % 4 >= 2);
      start = items_sent;
      paused = 1'b0;
      while (items_sent - start < PH_BUDGET[ph]) begin
        if (!paused && items_sent - start >= PH_BUDGET[ph] / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if (ph == HOLD_PHASE && !hold_asked && items_sent - start >= 10) begin
          long_hold_req = 1'b1;
          hold_asked = 1'b1;
        end
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          send_item(CMD_LOAD, draw_coarse(nx), draw_coarse(ny), draw_sample(), 1'b0, NO_LIT);
        end else if (pick < 17) begin
          col = draw_fine(nx);
          row = draw_fine(ny);
          prime_taps(col, row, 1'b0);
          send_item(CMD_READ, col, row, $urandom(), 1'b0, NO_LIT);
        end else begin
          col = $urandom_range(0, 2 * nx);
          row = $urandom_range(0, 2 * ny);
          prime_taps(col, row, 1'b1);
          send_item(CMD_READ, col, row, $urandom(), 1'b0, NO_LIT);
        end
      end
    end

    wait_drained();
    tx_steady = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Ran %0d loads (%0d more dropped off the store) and %0d reads, %0d off-grid,",
             n_loads, n_dropped, n_reads, n_offgrid);
    $display("over %0d interval settings; %0d results compared, %0d mismatches.",
             PHASES + 2, n_checked, n_fail);
    if (n_fail == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bgp_pkg.sv
hdl/bicubic_grid_prolongation_top.sv
bench/tb_bicubic_grid_prolongation_top.sv
